/* hw/rtl/srkr_pkg.sv */
package srkr_pkg;

   localparam int E_W  = 20;
   localparam int N_W  = 20;
   localparam int P_W  = 10;
   localparam int Q_W  = 19;
   localparam int D_W  = 20;
   localparam int ST_W = 2;
   localparam int SQ_W = N_W + 1;
   localparam int T_W  = N_W + 2;
   localparam int DIV_CNT_W = $clog2(N_W + 1);

   localparam int PRIME_BITS_DEFAULT = 10;

   localparam logic [ST_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [ST_W-1:0] STATUS_NO_FACTOR  = 2'd1;
   localparam logic [ST_W-1:0] STATUS_NO_INVERSE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRIAL_CHK,
      ST_TRIAL_DIV,
      ST_PHI,
      ST_INV_CHK,
      ST_INV_RED,
      ST_EU_CHK,
      ST_EU_DIV,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic           start;
      logic [N_W-1:0] dividend;
      logic [N_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic           done;
      logic [N_W-1:0] quotient;
      logic [N_W-1:0] remainder;
   } div_result_type;

endpackage

/* hw/rtl/srkr_if.sv */
interface srkr_req_if import srkr_pkg::*; ();
   logic           valid;
   logic           ready;
   logic [E_W-1:0] public_exp;
   logic [N_W-1:0] modulus;

   modport source (output valid, output public_exp, output modulus, input ready);
   modport sink (input valid, input public_exp, input modulus, output ready);
endinterface

interface srkr_rsp_if import srkr_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [P_W-1:0]  factor_small;
   logic [Q_W-1:0]  factor_large;
   logic [D_W-1:0]  private_exp;
   logic [ST_W-1:0] status;

   modport source (output valid, output factor_small, output factor_large,
                   output private_exp, output status, input ready);
   modport sink (input valid, input factor_small, input factor_large,
                 input private_exp, input status, output ready);
endinterface

/* hw/rtl/small_rsa_private_key_recovery.sv */
// Run time grows with the number of trial divisors tried and with the number of Euclid steps.
// The worst case is a smallest factor near 1021 after about 1020 candidates, then a long Euclid
// run; a modulus below 4 goes from the first trial check straight to the result.
// The trial divisions and the Euclid steps share one 20-bit divider.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset is synchronous and active high; it clears the sequencer and the result valid.
module small_rsa_private_key_recovery import srkr_pkg::*; #(
   parameter int PRIME_BITS = PRIME_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   srkr_req_if.sink      req,
   srkr_rsp_if.source    rsp
);

   localparam int CNT_W = PRIME_BITS + 1;

   state_type        state_ff, state_in;
   logic [E_W-1:0]   e_ff, e_in;
   logic [N_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic [P_W-1:0]   p_ff, p_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [N_W-1:0]   phi_ff, phi_in;
   logic [N_W-1:0]   r0_ff, r0_in;
   logic [N_W-1:0]   r1_ff, r1_in;
   logic signed [T_W-1:0] t0_ff, t0_in;
   logic signed [T_W-1:0] t1_ff, t1_in;
   logic [D_W-1:0]   d_ff, d_in;
   logic [ST_W-1:0]  status_ff, status_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [P_W-1:0]   rsp_p_ff, rsp_p_in;
   logic [Q_W-1:0]   rsp_q_ff, rsp_q_in;
   logic [D_W-1:0]   rsp_d_ff, rsp_d_in;
   logic [ST_W-1:0]  rsp_st_ff, rsp_st_in;

   div_cmd_type      div_cmd;
   div_result_type   div_res;

   logic             out_free;
   logic             trial_stop;
   logic [P_W+Q_W-1:0]      phi_prod;
   logic signed [2*T_W-1:0] t_prod;
   logic signed [2*T_W-1:0] t_next;
   logic signed [T_W-1:0]   t_wrap;

   srkr_div u_div (
      .clock  (clock),
      .reset  (reset),
      .cmd    (div_cmd),
      .result (div_res)
   );

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign trial_stop = i_ff[CNT_W-1] || (sq_ff > {1'b0, n_ff});
   assign phi_prod   = (p_ff - 1'b1) * (q_ff - 1'b1);
   assign t_prod     = $signed({1'b0, div_res.quotient}) * t1_ff;
   assign t_next     = t0_ff - t_prod;
   assign t_wrap     = t0_ff + $signed({2'b00, phi_ff});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req.valid) state_in = ST_TRIAL_CHK;
         ST_TRIAL_CHK: state_in = trial_stop ? ST_OUT : ST_TRIAL_DIV;
         ST_TRIAL_DIV: begin
            if (div_res.done) begin
               state_in = (div_res.remainder == '0) ? ST_PHI : ST_TRIAL_CHK;
            end
         end
         ST_PHI:       state_in = ST_INV_CHK;
         ST_INV_CHK:   state_in = (phi_ff <= N_W'(1)) ? ST_OUT : ST_INV_RED;
         ST_INV_RED:   if (div_res.done) state_in = ST_EU_CHK;
         ST_EU_CHK:    state_in = (r1_ff == '0) ? ST_FINISH : ST_EU_DIV;
         ST_EU_DIV:    if (div_res.done) state_in = ST_EU_CHK;
         ST_FINISH:    state_in = ST_OUT;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      e_in      = e_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      sq_in     = sq_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      phi_in    = phi_ff;
      r0_in     = r0_ff;
      r1_in     = r1_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      d_in      = d_ff;
      status_in = status_ff;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = n_ff;
      div_cmd.divisor  = N_W'(i_ff);
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_p_in  = rsp_p_ff;
      rsp_q_in  = rsp_q_ff;
      rsp_d_in  = rsp_d_ff;
      rsp_st_in = rsp_st_ff;
      unique case (state_ff)
         ST_IDLE: begin
            e_in  = req.public_exp;
            n_in  = req.modulus;
            i_in  = CNT_W'(2);
            sq_in = SQ_W'(4);
         end
         ST_TRIAL_CHK: begin
            if (trial_stop) begin
               p_in      = '0;
               q_in      = '0;
               d_in      = '0;
               status_in = STATUS_NO_FACTOR;
            end else begin
               div_cmd.start = 1'b1;
            end
         end
         ST_TRIAL_DIV: begin
            if (div_res.done) begin
               if (div_res.remainder == '0) begin
                  p_in = P_W'(i_ff);
                  q_in = div_res.quotient[Q_W-1:0];
               end else begin
                  // (i+1)^2 = i^2 + 2i + 1
                  sq_in = sq_ff + SQ_W'({i_ff, 1'b1});
                  i_in  = i_ff + 1'b1;
               end
            end
         end
         ST_PHI: phi_in = phi_prod[N_W-1:0];
         ST_INV_CHK: begin
            div_cmd.dividend = e_ff;
            div_cmd.divisor  = phi_ff;
            if (phi_ff <= N_W'(1)) begin
               d_in      = '0;
               status_in = STATUS_NO_INVERSE;
            end else begin
               div_cmd.start = 1'b1;
            end
         end
         ST_INV_RED: begin
            div_cmd.divisor = phi_ff;
            if (div_res.done) begin
               r0_in = phi_ff;
               r1_in = div_res.remainder;
               t0_in = '0;
               t1_in = T_W'(1);
            end
         end
         ST_EU_CHK: begin
            div_cmd.dividend = r0_ff;
            div_cmd.divisor  = r1_ff;
            div_cmd.start    = (r1_ff != '0);
         end
         ST_EU_DIV: begin
            div_cmd.dividend = r0_ff;
            div_cmd.divisor  = r1_ff;
            if (div_res.done) begin
               r0_in = r1_ff;
               r1_in = div_res.remainder;
               t0_in = t1_ff;
               t1_in = t_next[T_W-1:0];
            end
         end
         ST_FINISH: begin
            if (r0_ff != N_W'(1)) begin
               d_in      = '0;
               status_in = STATUS_NO_INVERSE;
            end else begin
               d_in      = t0_ff[T_W-1] ? t_wrap[D_W-1:0] : t0_ff[D_W-1:0];
               status_in = STATUS_OK;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_p_in     = p_ff;
               rsp_q_in     = q_ff;
               rsp_d_in     = d_ff;
               rsp_st_in    = status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      e_ff      <= e_in;
      n_ff      <= n_in;
      i_ff      <= i_in;
      sq_ff     <= sq_in;
      p_ff      <= p_in;
      q_ff      <= q_in;
      phi_ff    <= phi_in;
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      t0_ff     <= t0_in;
      t1_ff     <= t1_in;
      d_ff      <= d_in;
      status_ff <= status_in;
      rsp_p_ff  <= rsp_p_in;
      rsp_q_ff  <= rsp_q_in;
      rsp_d_ff  <= rsp_d_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.factor_small = rsp_p_ff;
   assign rsp.factor_large = rsp_q_ff;
   assign rsp.private_exp  = rsp_d_ff;
   assign rsp.status       = rsp_st_ff;

endmodule

/* hw/rtl/srkr_div.sv */
module srkr_div import srkr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  div_cmd_type    cmd,
   output div_result_type result
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [N_W-1:0]       quo_ff, quo_in;
   logic [N_W-1:0]       rem_ff, rem_in;
   logic [N_W:0]         shifted;
   logic [N_W:0]         diff;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      shifted  = {rem_ff, quo_ff[N_W-1]};
      diff     = shifted - {1'b0, cmd.divisor};
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_W'(N_W);
         quo_in   = cmd.dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, cmd.divisor}) begin
            rem_in = diff[N_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[N_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

/* hw/rtl/srkr_checker.sv */
module srkr_checker import srkr_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [P_W-1:0]  rsp_factor_small,
   input logic [Q_W-1:0]  rsp_factor_large,
   input logic [D_W-1:0]  rsp_private_exp,
   input logic [ST_W-1:0] rsp_status
);

   // A stalled result must hold its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_factor_small)
         && $stable(rsp_factor_large) && $stable(rsp_private_exp) && $stable(rsp_status))
      else $error("result changed while stalled");

   // Only one request is worked on at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_NO_FACTOR)
         || (rsp_status == STATUS_NO_INVERSE))
      else $error("undefined status code");

   a_no_factor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_NO_FACTOR) |->
         (rsp_factor_small == '0) && (rsp_factor_large == '0) && (rsp_private_exp == '0))
      else $error("failed factorization reports nonzero fields");

   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK) |->
         (rsp_private_exp != '0) && (rsp_factor_small > P_W'(1)))
      else $error("successful result with invalid fields");

endmodule

bind small_rsa_private_key_recovery srkr_checker u_srkr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_factor_small (rsp.factor_small),
   .rsp_factor_large (rsp.factor_large),
   .rsp_private_exp  (rsp.private_exp),
   .rsp_status       (rsp.status)
);
